// ----- design/utd_pkg.sv -----
// Shared types, constants and calendar tables for the timestamp difference block.
package utd_pkg;

  localparam int DAYS_W = 26;
  localparam int TOD_W  = 27;
  localparam int DIFF_W = 48;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 2'd1;

  localparam logic [CFG_W-1:0] MIN_YEAR_RST = 12'd1970;
  localparam logic [CFG_W-1:0] MAX_YEAR_RST = 12'd2100;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 199728
  localparam logic [17:0] RECIP_100   = 18'd167773;
  localparam int          RECIP_SHIFT = 24;

  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 26'd365;
  localparam logic [TOD_W-1:0]  MS_PER_HOUR   = 27'd3600000;
  localparam logic [TOD_W-1:0]  MS_PER_MIN    = 27'd60000;
  localparam logic [15:0]       MS_PER_MINUTE_LIM = 16'd60000;

  // ms per day = 84375 << 10
  localparam logic signed [17:0] DAY_MS_ODD   = 18'sd84375;
  localparam int                 DAY_MS_SHIFT = 10;

  typedef struct packed {
    logic signed [DAYS_W-1:0] days;
    logic [TOD_W-1:0]         tod;
    logic                     ok;
  } utd_stamp_t;

  // Days before the first of the month; months outside 1..12 give 0.
  function automatic logic [8:0] days_before_month(input logic [3:0] month,
                                                   input logic leap);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = leap ? 9'd60  : 9'd59;
      4'd4:    d = leap ? 9'd91  : 9'd90;
      4'd5:    d = leap ? 9'd121 : 9'd120;
      4'd6:    d = leap ? 9'd152 : 9'd151;
      4'd7:    d = leap ? 9'd182 : 9'd181;
      4'd8:    d = leap ? 9'd213 : 9'd212;
      4'd9:    d = leap ? 9'd244 : 9'd243;
      4'd10:   d = leap ? 9'd274 : 9'd273;
      4'd11:   d = leap ? 9'd305 : 9'd304;
      4'd12:   d = leap ? 9'd335 : 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- design/utd_stamp.sv -----
// Three-stage conversion of one calendar stamp into day count, time of day and validity.
module utd_stamp #(
  parameter int YEAR_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [YEAR_BITS-1:0]      year,
  input  logic [3:0]                month,
  input  logic [4:0]                day,
  input  logic [4:0]                hour,
  input  logic [5:0]                minute,
  input  logic [15:0]               millis,
  input  logic [utd_pkg::CFG_W-1:0] min_year,
  input  logic [utd_pkg::CFG_W-1:0] max_year,
  output logic                      res_vld,
  output utd_pkg::utd_stamp_t       res
);

  localparam int PROD_W = YEAR_BITS + 19;
  localparam int Q_W    = YEAR_BITS - 5;
  localparam int CMP_W  = (YEAR_BITS > utd_pkg::CFG_W) ? YEAR_BITS : utd_pkg::CFG_W;
  localparam int DW     = utd_pkg::DAYS_W;
  localparam int TW     = utd_pkg::TOD_W;

  // stage 1
  logic                 vld1;
  logic [PROD_W-1:0]    prod1;
  logic [YEAR_BITS-1:0] year1;
  logic [3:0]           month1;
  logic [4:0]           day1;
  logic [4:0]           hour1;
  logic [5:0]           minute1;
  logic [15:0]          millis1;
  logic [TW-1:0]        hr_ms1;
  logic [TW-1:0]        min_ms1;

  logic [YEAR_BITS:0]   yp99;
  logic [PROD_W-1:0]    prod_next;

  // stage 2
  logic                 vld2;
  logic [Q_W-1:0]       q2;
  logic signed [9:0]    yday2;
  logic [DW-1:0]        base2;
  logic [TW-1:0]        tod2;
  logic                 ok2;

  logic [Q_W-1:0]       q1;
  logic [YEAR_BITS+1:0] q100;
  logic                 div100;
  logic                 leap;
  logic [8:0]           md;
  logic [4:0]           dim;
  logic                 month_ok;
  logic [YEAR_BITS:0]   y3;
  logic [CMP_W-1:0]     yc;
  logic                 ok_next;
  logic signed [9:0]    yday_next;
  logic [DW-1:0]        base_next;

  // stage 3
  logic [Q_W:0]         q2p3;
  logic [DW-1:0]        days_next;

  assign yp99      = {1'b0, year} + (YEAR_BITS+1)'(99);
  assign prod_next = PROD_W'(yp99) * PROD_W'(utd_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    prod1   <= prod_next;
    year1   <= year;
    month1  <= month;
    day1    <= day;
    hour1   <= hour;
    minute1 <= minute;
    millis1 <= millis;
    hr_ms1  <= TW'(hour) * utd_pkg::MS_PER_HOUR;
    min_ms1 <= TW'(minute) * utd_pkg::MS_PER_MIN;
  end

  // q1 = ceil(year / 100); year is a multiple of 100 when 100 * q1 lands on it
  always_comb begin
    q1       = prod1[utd_pkg::RECIP_SHIFT +: Q_W];
    q100     = (YEAR_BITS+2)'(q1) * (YEAR_BITS+2)'(100);
    div100   = (q100 == {2'b00, year1});
    leap     = div100 ? (year1[3:0] == 4'd0) : (year1[1:0] == 2'd0);
    month_ok = month1 inside {[4'd1:4'd12]};
    md       = month_ok ? utd_pkg::days_before_month(month1, leap) : 9'd0;
    dim      = utd_pkg::month_length(month1, leap);
    yc       = CMP_W'(year1);
    ok_next  = (yc >= CMP_W'(min_year)) && (yc <= CMP_W'(max_year)) && month_ok &&
               (day1 != 5'd0) && (day1 <= dim) && (hour1 < 5'd24) &&
               (minute1 < 6'd60) && (millis1 < utd_pkg::MS_PER_MINUTE_LIM);
    yday_next = $signed({1'b0, md}) + $signed({5'b00000, day1}) - 10'sd1;
    y3        = {1'b0, year1} + (YEAR_BITS+1)'(3);
    base_next = DW'(year1) * utd_pkg::DAYS_PER_YEAR + DW'(y3[YEAR_BITS:2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    q2    <= q1;
    yday2 <= yday_next;
    base2 <= base_next;
    tod2  <= hr_ms1 + min_ms1 + TW'(millis1);
    ok2   <= ok_next;
  end

  assign q2p3      = {1'b0, q2} + (Q_W+1)'(3);
  assign days_next = base2 - DW'(q2) + DW'(q2p3[Q_W:2]) + DW'(yday2);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= vld2;
    end
    res.days <= days_next;
    res.tod  <= tod2;
    res.ok   <= ok2;
  end

endmodule

// ----- design/utd_diff.sv -----
// Three-stage subtraction and scaling of two converted stamps into milliseconds.
module utd_diff (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld_a,
  input  logic                              vld_b,
  input  utd_pkg::utd_stamp_t               in_a,
  input  utd_pkg::utd_stamp_t               in_b,
  output logic                              done,
  output logic signed [utd_pkg::DIFF_W-1:0] difference_ms,
  output logic                              a_valid,
  output logic                              b_valid
);

  localparam int DW = utd_pkg::DAYS_W;
  localparam int TW = utd_pkg::TOD_W;
  localparam int PW = DW + 1 + 18;
  localparam int OW = utd_pkg::DIFF_W;
  localparam int SH = utd_pkg::DAY_MS_SHIFT;

  logic                 in_vld;
  logic                 vld4;
  logic signed [DW:0]   dd4;
  logic signed [TW:0]   td4;
  logic                 ok_a4;
  logic                 ok_b4;

  logic                 vld5;
  logic signed [PW-1:0] prod5;
  logic signed [TW:0]   td5;
  logic                 ok_a5;
  logic                 ok_b5;

  logic [OW-1:0]        diff_next;

  assign in_vld = vld_a & vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= in_vld;
    end
    dd4   <= {in_a.days[DW-1], in_a.days} - {in_b.days[DW-1], in_b.days};
    td4   <= $signed({1'b0, in_a.tod}) - $signed({1'b0, in_b.tod});
    ok_a4 <= in_a.ok;
    ok_b4 <= in_b.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
    prod5 <= dd4 * utd_pkg::DAY_MS_ODD;
    td5   <= td4;
    ok_a5 <= ok_a4;
    ok_b5 <= ok_b4;
  end

  // days * 84375, shifted by 10, plus the time-of-day difference
  assign diff_next = {prod5[OW-SH-1:0], {SH{1'b0}}} + OW'(td5);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld5;
    end
    difference_ms <= diff_next;
    a_valid       <= ok_a5;
    b_valid       <= ok_b5;
  end

  a_stamps_aligned: assert property (@(posedge clk) disable iff (rst)
    vld_a == vld_b)
    else $error("stamp pipelines out of step");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_vld, 3))
    else $error("result strobe without a matching word");

  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    $past(vld4 && dd4 == '0 && td4 == '0, 2) |-> (done && difference_ms == '0))
    else $error("equal stamps gave a nonzero difference");

endmodule

// ----- design/utc_timestamp_difference_top.sv -----
// Top level of the calendar timestamp difference block.
//
// Usage: drive the two stamps (a and b) on the input ports and pulse start;
// a word is taken at each clock edge with start high and busy low. The block
// returns a minus b in milliseconds together with one validity flag per
// stamp, checked against the field ranges, the month length and the year
// window in min_year / max_year.
// The done strobe rises once the word has passed the stamp stages and the
// combining stages below, and each result is shown with it for exactly one
// cycle. A new word may be started in every cycle while busy is low: three
// stages convert each stamp (reciprocal multiply for the century terms,
// table lookup, day sum) and three combine them (subtract, scale by the day
// length, add time of day).
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// writes min_year (index 0) or max_year (index 1); it is always ready.
// Reset loads 1970 and 2100 into the year window and empties the pipeline;
// busy is high for the cycle after reset. The receiver cannot stall: done
// is a strobe and each result is shown once.
module utc_timestamp_difference_top #(
  parameter int YEAR_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [YEAR_BITS-1:0]                   year_a,
  input  logic [3:0]                             month_a,
  input  logic [4:0]                             day_a,
  input  logic [4:0]                             hour_a,
  input  logic [5:0]                             minute_a,
  input  logic [15:0]                            millis_a,
  input  logic [YEAR_BITS-1:0]                   year_b,
  input  logic [3:0]                             month_b,
  input  logic [4:0]                             day_b,
  input  logic [4:0]                             hour_b,
  input  logic [5:0]                             minute_b,
  input  logic [15:0]                            millis_b,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [utd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [utd_pkg::CFG_W-1:0]              cfg_data,
  output logic                                   done,
  output logic signed [utd_pkg::DIFF_W-1:0]      difference_ms,
  output logic                                   a_valid,
  output logic                                   b_valid
);

  logic                        accept;
  logic [utd_pkg::CFG_W-1:0]   min_year;
  logic [utd_pkg::CFG_W-1:0]   max_year;
  logic                        vld_a;
  logic                        vld_b;
  utd_pkg::utd_stamp_t         res_a;
  utd_pkg::utd_stamp_t         res_b;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= utd_pkg::MIN_YEAR_RST;
      max_year <= utd_pkg::MAX_YEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        utd_pkg::CFG_MIN_YEAR: min_year <= cfg_data;
        utd_pkg::CFG_MAX_YEAR: max_year <= cfg_data;
        default: ;
      endcase
    end
  end

  utd_stamp #(.YEAR_BITS(YEAR_BITS)) u_stamp_a (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .year     (year_a),
    .month    (month_a),
    .day      (day_a),
    .hour     (hour_a),
    .minute   (minute_a),
    .millis   (millis_a),
    .min_year (min_year),
    .max_year (max_year),
    .res_vld  (vld_a),
    .res      (res_a)
  );

  utd_stamp #(.YEAR_BITS(YEAR_BITS)) u_stamp_b (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (accept),
    .year     (year_b),
    .month    (month_b),
    .day      (day_b),
    .hour     (hour_b),
    .minute   (minute_b),
    .millis   (millis_b),
    .min_year (min_year),
    .max_year (max_year),
    .res_vld  (vld_b),
    .res      (res_b)
  );

  utd_diff u_diff (
    .clk           (clk),
    .rst           (rst),
    .vld_a         (vld_a),
    .vld_b         (vld_b),
    .in_a          (res_a),
    .in_b          (res_b),
    .done          (done),
    .difference_ms (difference_ms),
    .a_valid       (a_valid),
    .b_valid       (b_valid)
  );

endmodule

// ----- tb/sv/utd_result_checker.sv -----
// Watches the stamp, config and result channels, predicts each difference and compares.
`timescale 1ns / 1ps

module utd_result_checker
  import utd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [11:0]             year_a,
  input  logic [3:0]              month_a,
  input  logic [4:0]              day_a,
  input  logic [4:0]              hour_a,
  input  logic [5:0]              minute_a,
  input  logic [15:0]             millis_a,
  input  logic [11:0]             year_b,
  input  logic [3:0]              month_b,
  input  logic [4:0]              day_b,
  input  logic [4:0]              hour_b,
  input  logic [5:0]              minute_b,
  input  logic [15:0]             millis_b,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    done,
  input  logic signed [DIFF_W-1:0] difference_ms,
  input  logic                    a_valid,
  input  logic                    b_valid,
  output int                      outstanding,
  output int                      mismatches
);

  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic              a_ok;
    logic              b_ok;
  } diff_word_t;

  diff_word_t diffs_due[$];
  logic [CFG_W-1:0] lo_year;
  logic [CFG_W-1:0] hi_year;

  function automatic bit leap_year(input logic [11:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input bit leap);
    if (m == 4'd2) return leap ? 5'd29 : 5'd28;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) return 5'd30;
    return 5'd31;
  endfunction

  // Milliseconds since the start of year 0; an out-of-range month adds no days.
  function automatic longint stamp_millis(input logic [11:0] y, input logic [3:0] mo,
                                          input logic [4:0] d, input logic [4:0] h,
                                          input logic [5:0] mi, input logic [15:0] ms);
    longint n;
    longint days;
    n = longint'(y);
    days = 365 * n + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
    if (mo >= 4'd1 && mo <= 4'd12)
      for (logic [3:0] m = 4'd1; m < mo; m++)
        days += longint'(month_days(m, leap_year(y)));
    days += longint'(d) - 1;
    return days * 64'sd86400000 + longint'(h) * 64'sd3600000 + longint'(mi) * 64'sd60000
         + longint'(ms);
  endfunction

  function automatic bit stamp_is_valid(input logic [11:0] y, input logic [3:0] mo,
                                        input logic [4:0] d, input logic [4:0] h,
                                        input logic [5:0] mi, input logic [15:0] ms);
    if (y < lo_year || y > hi_year || mo < 4'd1 || mo > 4'd12) return 1'b0;
    if (d < 5'd1 || d > month_days(mo, leap_year(y))) return 1'b0;
    return (h < 5'd24) && (mi < 6'd60) && (ms < 16'd60000);
  endfunction

  always @(posedge clk) begin
    diff_word_t want;
    longint     delta;
    int         bad;
    bad = 0;
    if (rst) begin
      lo_year <= MIN_YEAR_RST;
      hi_year <= MAX_YEAR_RST;
      diffs_due.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_YEAR: lo_year <= cfg_data;
          CFG_MAX_YEAR: hi_year <= cfg_data;
          default: ;
        endcase
      end
      // retire first so a stray strobe never matches a word taken this cycle
      if (done) begin
        if (diffs_due.size() == 0) begin
          $display("%0t: result with nothing pending: difference_ms %0d", $time,
                   difference_ms);
          bad++;
        end else begin
          want = diffs_due.pop_front();
          if (difference_ms !== want.diff) begin
            $display("%0t: difference_ms expected %0d actual %0d", $time,
                     $signed(want.diff), difference_ms);
            bad++;
          end
          if (a_valid !== want.a_ok) begin
            $display("%0t: a_valid expected %0b actual %0b", $time, want.a_ok, a_valid);
            bad++;
          end
          if (b_valid !== want.b_ok) begin
            $display("%0t: b_valid expected %0b actual %0b", $time, want.b_ok, b_valid);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        delta = stamp_millis(year_a, month_a, day_a, hour_a, minute_a, millis_a)
              - stamp_millis(year_b, month_b, day_b, hour_b, minute_b, millis_b);
        want.diff = delta[DIFF_W-1:0];
        want.a_ok = stamp_is_valid(year_a, month_a, day_a, hour_a, minute_a, millis_a);
        want.b_ok = stamp_is_valid(year_b, month_b, day_b, hour_b, minute_b, millis_b);
        diffs_due.push_back(want);
      end
      mismatches <= mismatches + bad;
    end
    outstanding <= diffs_due.size();
  end

endmodule

// ----- tb/sv/tb_utc_timestamp_difference_top.sv -----
// Stimulus and verdict for the timestamp difference block.
`timescale 1ns / 1ps

module tb_utc_timestamp_difference_top;
  import utd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] millis;
  } stamp_t;

  typedef enum int {STAMP_IN_WINDOW, STAMP_ANY_YEAR, STAMP_ONE_BAD, STAMP_NOISE} stamp_kind_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  stamp_t sa = '0;
  stamp_t sb = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic signed [DIFF_W-1:0] difference_ms;
  logic a_valid;
  logic b_valid;
  int outstanding;
  int mismatches;
  int unsigned win_lo = 1970;
  int unsigned win_hi = 2100;

  utc_timestamp_difference_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .year_a(sa.year), .month_a(sa.month), .day_a(sa.day), .hour_a(sa.hour),
    .minute_a(sa.minute), .millis_a(sa.millis),
    .year_b(sb.year), .month_b(sb.month), .day_b(sb.day), .hour_b(sb.hour),
    .minute_b(sb.minute), .millis_b(sb.millis),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done), .difference_ms(difference_ms), .a_valid(a_valid), .b_valid(b_valid)
  );

  utd_result_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .year_a(sa.year), .month_a(sa.month), .day_a(sa.day), .hour_a(sa.hour),
    .minute_a(sa.minute), .millis_a(sa.millis),
    .year_b(sb.year), .month_b(sb.month), .day_b(sb.day), .hour_b(sb.hour),
    .minute_b(sb.minute), .millis_b(sb.millis),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done), .difference_ms(difference_ms), .a_valid(a_valid), .b_valid(b_valid),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_utc_timestamp_difference_top: done, errors");
    $finish;
  end

  function automatic stamp_t mk(input int y, input int mo, input int d, input int h,
                                input int mi, input int ms);
    stamp_t s;
    s.year = 12'(y); s.month = 4'(mo); s.day = 5'(d); s.hour = 5'(h);
    s.minute = 6'(mi); s.millis = 16'(ms);
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic stamp_t rand_stamp(input stamp_kind_t kind);
    stamp_t s;
    int unsigned lo, hi;
    lo = (win_lo <= win_hi) ? win_lo : win_hi;
    hi = (win_lo <= win_hi) ? win_hi : win_lo;
    s.year   = 12'((kind == STAMP_IN_WINDOW) ? $urandom_range(lo, hi)
                                             : $urandom_range(0, 4095));
    s.month  = 4'($urandom_range(1, 12));
    s.day    = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                              : $urandom_range(1, 28));
    s.hour   = 5'($urandom_range(0, 23));
    s.minute = 6'($urandom_range(0, 59));
    s.millis = 16'($urandom_range(0, 59999));
    if (kind == STAMP_ONE_BAD) begin
      case ($urandom_range(0, 4))
        0: s.month  = 4'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15));
        1: s.day    = 5'd0;
        2: s.hour   = 5'($urandom_range(24, 31));
        3: s.minute = 6'($urandom_range(60, 63));
        default: s.millis = 16'($urandom_range(60000, 65535));
      endcase
    end else if (kind == STAMP_NOISE) begin
      s[47:32] = 16'($urandom);
      s[31:0]  = $urandom;
    end
    return s;
  endfunction

  function automatic stamp_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return STAMP_IN_WINDOW;
    if (r < 75) return STAMP_ANY_YEAR;
    if (r < 90) return STAMP_ONE_BAD;
    return STAMP_NOISE;
  endfunction

  // hold the word until taken, then idle for a random gap
  task automatic drive_pair(input stamp_t a, input stamp_t b);
    int unsigned gap;
    sa <= a;
    sb <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(input int unsigned lo, input int unsigned hi,
                            input bit poke_spare);
    write_reg(CFG_MIN_YEAR, lo);
    write_reg(CFG_MAX_YEAR, hi);
    if (poke_spare) write_reg(CFG_SPARE, $urandom_range(0, 4095));
    cfg_valid <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  task automatic random_pairs(input int count);
    stamp_t a;
    stamp_t b;
    for (int i = 0; i < count; i++) begin
      a = rand_stamp(pick_kind());
      b = ($urandom_range(0, 15) == 0) ? a : rand_stamp(pick_kind());
      drive_pair(a, b);
      if ($urandom_range(0, 24) == 0) drain();
    end
  endtask

  initial begin
    int unsigned lo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset window 1970..2100
    drive_pair(mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0));
    drive_pair(mk(4095, 15, 31, 31, 63, 65535), mk(0, 0, 0, 0, 0, 0));
    drive_pair(mk(0, 0, 0, 0, 0, 0), mk(4095, 15, 31, 31, 63, 65535));
    drive_pair(mk(2000, 2, 29, 12, 30, 30000), mk(1970, 1, 1, 0, 0, 0));
    drive_pair(mk(1900, 2, 29, 0, 0, 0), mk(2100, 3, 1, 0, 0, 0));
    drive_pair(mk(2100, 2, 29, 0, 0, 0), mk(2096, 2, 29, 23, 59, 59999));
    drive_pair(mk(2020, 0, 15, 1, 2, 3), mk(2020, 13, 15, 1, 2, 3));
    drive_pair(mk(2021, 6, 0, 0, 0, 0), mk(2021, 5, 31, 0, 0, 0));
    drive_pair(mk(2022, 7, 4, 24, 0, 0), mk(2022, 7, 4, 23, 0, 0));
    drive_pair(mk(2022, 7, 4, 5, 60, 0), mk(2022, 7, 4, 5, 59, 0));
    drive_pair(mk(2022, 7, 4, 5, 5, 60000), mk(2022, 7, 4, 5, 5, 59999));
    drive_pair(mk(1970, 1, 1, 0, 0, 0), mk(2100, 12, 31, 23, 59, 59999));
    drive_pair(mk(1969, 12, 31, 23, 59, 59999), mk(2101, 1, 1, 0, 0, 0));
    drive_pair(mk(2024, 12, 31, 23, 59, 59999), mk(2025, 1, 1, 0, 0, 0));
    drive_pair(mk(2023, 4, 31, 8, 0, 0), mk(2023, 4, 30, 8, 0, 0));
    drive_pair(mk(2050, 15, 31, 0, 0, 0), mk(2000, 12, 31, 0, 0, 0));
    drive_pair(mk(2012, 9, 17, 14, 3, 1234), mk(2012, 9, 17, 14, 3, 1234));
    drain();

    // full year range
    set_window(0, 4095, 1'b1);
    drive_pair(mk(0, 1, 1, 0, 0, 0), mk(4095, 12, 31, 23, 59, 59999));
    drive_pair(mk(4095, 12, 31, 23, 59, 59999), mk(0, 1, 1, 0, 0, 0));
    drive_pair(mk(400, 2, 29, 0, 0, 0), mk(100, 2, 29, 0, 0, 0));
    random_pairs(40);
    drain();

    // min above max: nothing is valid
    set_window(4095, 0, 1'b0);
    random_pairs(10);
    drain();

    // single-year window
    set_window(2000, 2000, 1'b0);
    random_pairs(15);
    drain();

    repeat (3) begin
      lo = $urandom_range(1500, 2100);
      set_window(lo, lo + $urandom_range(0, 300), 1'b1);
      random_pairs(18);
      drain();
    end

    if (mismatches == 0)
      $display("tb_utc_timestamp_difference_top: done, clean");
    else
      $display("tb_utc_timestamp_difference_top: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/utd_pkg.sv
design/utd_stamp.sv
design/utd_diff.sv
design/utc_timestamp_difference_top.sv
tb/sv/utd_result_checker.sv
tb/sv/tb_utc_timestamp_difference_top.sv
